// ===== sv/qnr_pkg.sv =====
`timescale 1ns / 1ps

package qnr_pkg;

   localparam int FRAC_BITS      = 16;
   localparam int WORD_BITS      = 32;
   localparam int IO_BITS        = 32;
   localparam int TOL_BITS       = 16;
   localparam int LIM_BITS       = 12;
   localparam int NUDGE_BITS     = 16;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;

   localparam int CNT_BITS     = LIM_BITS + 1;
   localparam int ACC_BITS     = WORD_BITS + 2;
   localparam int PROD_BITS    = 2 * WORD_BITS;
   localparam int NUM_BITS     = WORD_BITS + FRAC_BITS;
   localparam int DIV_CNT_BITS = $clog2(NUM_BITS + 1);
   localparam int EXT_BITS     = (WORD_BITS > IO_BITS ? WORD_BITS : IO_BITS) + 1;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic        [WORD_BITS-1:0] mag_type;
   typedef logic        [IO_BITS-1:0]   io_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam logic signed [IO_BITS-1:0] IO_MAX = {1'b0, {(IO_BITS-1){1'b1}}};
   localparam logic signed [IO_BITS-1:0] IO_MIN = {1'b1, {(IO_BITS-1){1'b0}}};

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOLERANCE  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ITER_LIMIT = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NUDGE_STEP = CSR_INDEX_BITS'(2);

   localparam logic [TOL_BITS-1:0]   TOL_RESET   = TOL_BITS'(1);
   localparam logic [LIM_BITS-1:0]   LIM_RESET   = LIM_BITS'(1000);
   localparam logic [NUDGE_BITS-1:0] NUDGE_RESET = NUDGE_BITS'(1);

   function automatic word_type clamp_acc(input logic signed [ACC_BITS-1:0] v);
      logic signed [ACC_BITS-1:0] hi;
      logic signed [ACC_BITS-1:0] lo;
      hi = ACC_BITS'(WORD_MAX);
      lo = ACC_BITS'(WORD_MIN);
      if (v > hi) begin
         return WORD_MAX;
      end else if (v < lo) begin
         return WORD_MIN;
      end
      return word_type'(v[WORD_BITS-1:0]);
   endfunction

   function automatic mag_type magnitude(input word_type v);
      return v[WORD_BITS-1] ? mag_type'(-v) : mag_type'(v);
   endfunction

   // sign and magnitude to a saturated word
   function automatic word_type sat_sm(input logic neg, input logic [PROD_BITS-1:0] m);
      logic [PROD_BITS-1:0] half;
      half = {{(PROD_BITS-WORD_BITS){1'b0}}, WORD_MIN};
      if (m >= half) begin
         return neg ? WORD_MIN : WORD_MAX;
      end
      return neg ? word_type'(mag_type'(0) - m[WORD_BITS-1:0])
                 : word_type'(m[WORD_BITS-1:0]);
   endfunction

   function automatic word_type in_word(input io_type raw);
      logic signed [EXT_BITS-1:0] ext;
      logic signed [EXT_BITS-1:0] hi;
      logic signed [EXT_BITS-1:0] lo;
      ext = EXT_BITS'(signed'(raw));
      hi  = EXT_BITS'(WORD_MAX);
      lo  = EXT_BITS'(WORD_MIN);
      if (ext > hi) begin
         return WORD_MAX;
      end else if (ext < lo) begin
         return WORD_MIN;
      end
      return word_type'(ext[WORD_BITS-1:0]);
   endfunction

   function automatic io_type out_word(input word_type x);
      logic signed [EXT_BITS-1:0] ext;
      logic signed [EXT_BITS-1:0] hi;
      logic signed [EXT_BITS-1:0] lo;
      ext = EXT_BITS'(x);
      hi  = EXT_BITS'(IO_MAX);
      lo  = EXT_BITS'(IO_MIN);
      if (ext > hi) begin
         return io_type'(IO_MAX);
      end else if (ext < lo) begin
         return io_type'(IO_MIN);
      end
      return ext[IO_BITS-1:0];
   endfunction

   typedef enum logic [12:0] {
      S_IDLE = 13'b0000000000001,
      S_MAX  = 13'b0000000000010,
      S_SAX  = 13'b0000000000100,
      S_DER  = 13'b0000000001000,
      S_MAXX = 13'b0000000010000,
      S_MBX  = 13'b0000000100000,
      S_SUM  = 13'b0000001000000,
      S_FSUM = 13'b0000010000000,
      S_DVI  = 13'b0000100000000,
      S_DIV  = 13'b0001000000000,
      S_UPD  = 13'b0010000000000,
      S_FIN  = 13'b0100000000000,
      S_SPARE = 13'b1000000000000
   } state_type;

endpackage

// ===== sv/qnr_if.sv =====
`timescale 1ns / 1ps

interface qnr_req_if import qnr_pkg::*; ();
   logic   valid;
   logic   ready;
   io_type coef_a;
   io_type coef_b;
   io_type coef_c;
   io_type start_x;

   modport source (output valid, coef_a, coef_b, coef_c, start_x, input ready);
   modport sink   (input valid, coef_a, coef_b, coef_c, start_x, output ready);
endinterface

interface qnr_rsp_if import qnr_pkg::*; ();
   logic                valid;
   logic                ready;
   io_type              root;
   logic [LIM_BITS-1:0] steps_taken;
   logic                found;

   modport source (output valid, root, steps_taken, found, input ready);
   modport sink   (input valid, root, steps_taken, found, output ready);
endinterface

// ===== sv/quadratic_newton_root.sv =====
// Each Newton step passes S_MAX, S_SAX, S_DER, S_MAXX, S_MBX, S_SUM, S_FSUM, S_DVI,
// S_DIV and S_UPD; a zero derivative nudges x and repeats S_MAX to S_DER. The
// 48-bit restoring divider sets the step time, beside three passes through one
// shared multiplier. Flow: one request at a time; req ready only when idle, and the
// finish waits while the previous result still sits in the output register.
// Reset (synchronous, active high): idle, no result, tolerance 1, limit 1000, nudge 1.
`timescale 1ns / 1ps

module quadratic_newton_root import qnr_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   qnr_req_if.sink                   req_ch,
   qnr_rsp_if.source                 rsp_ch,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   state_type state_ff, state_in;

   logic [TOL_BITS-1:0]   tol_ff, tol_in;
   logic [LIM_BITS-1:0]   lim_ff, lim_in;
   logic [NUDGE_BITS-1:0] nudge_ff, nudge_in;

   word_type a_ff, a_in;
   word_type b_ff, b_in;
   word_type c_ff, c_in;
   word_type x_ff, x_in;
   word_type ax_ff, ax_in;
   word_type axx_ff, axx_in;
   word_type bx_ff, bx_in;
   word_type d_ff, d_in;
   word_type f_ff, f_in;

   logic [PROD_BITS-1:0]    prod_ff, prod_in;
   logic                    neg_ff, neg_in;
   mag_type                 rem_ff, rem_in;
   mag_type                 den_ff, den_in;
   logic [NUM_BITS-1:0]     quo_ff, quo_in;
   logic                    qneg_ff, qneg_in;
   logic [DIV_CNT_BITS-1:0] dcnt_ff, dcnt_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [CNT_BITS-1:0]     nudges_ff, nudges_in;

   logic                rsp_valid_ff, rsp_valid_in;
   io_type              root_ff, root_in;
   logic [LIM_BITS-1:0] steps_ff, steps_in;
   logic                found_ff, found_in;

   mag_type              mul_l;
   mag_type              mul_r;
   logic                 mul_neg;
   logic [PROD_BITS-1:0] mul_p;
   word_type             prod_sat;
   word_type             dbl;
   word_type             d_calc;
   word_type             part;
   logic [WORD_BITS:0]   trial;
   logic                 qbit;
   word_type             delta;
   logic [CNT_BITS-1:0]  count_nx;
   logic [CNT_BITS-1:0]  lim_ext;
   logic                 ok;

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.root        = root_ff;
   assign rsp_ch.steps_taken = steps_ff;
   assign rsp_ch.found       = found_ff;

   // shared multiplier
   always_comb begin
      mul_r = magnitude(x_ff);
      case (state_ff)
         S_MAXX: begin
            mul_l   = magnitude(ax_ff);
            mul_neg = ax_ff[WORD_BITS-1] ^ x_ff[WORD_BITS-1];
         end
         S_MBX: begin
            mul_l   = magnitude(b_ff);
            mul_neg = b_ff[WORD_BITS-1] ^ x_ff[WORD_BITS-1];
         end
         default: begin
            mul_l   = magnitude(a_ff);
            mul_neg = a_ff[WORD_BITS-1] ^ x_ff[WORD_BITS-1];
         end
      endcase
      mul_p = PROD_BITS'(mul_l) * PROD_BITS'(mul_r);
   end

   assign prod_sat = sat_sm(neg_ff, prod_ff >> FRAC_BITS);
   assign dbl      = clamp_acc(ACC_BITS'(ax_ff) + ACC_BITS'(ax_ff));
   assign d_calc   = clamp_acc(ACC_BITS'(dbl) + ACC_BITS'(b_ff));
   assign part     = clamp_acc(ACC_BITS'(axx_ff) + ACC_BITS'(bx_ff));
   assign trial    = {rem_ff, quo_ff[NUM_BITS-1]};
   assign qbit     = (trial >= {1'b0, den_ff});
   assign delta    = sat_sm(qneg_ff, PROD_BITS'(quo_ff));
   assign count_nx = count_ff + CNT_BITS'(1);
   assign lim_ext  = {1'b0, lim_ff};
   assign ok       = (count_ff <= lim_ext) && (nudges_ff <= lim_ext) &&
                     (count_ff != CNT_BITS'(0));

   always_comb begin
      state_in     = state_ff;
      tol_in       = tol_ff;
      lim_in       = lim_ff;
      nudge_in     = nudge_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      x_in         = x_ff;
      ax_in        = ax_ff;
      axx_in       = axx_ff;
      bx_in        = bx_ff;
      d_in         = d_ff;
      f_in         = f_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      quo_in       = quo_ff;
      qneg_in      = qneg_ff;
      dcnt_in      = dcnt_ff;
      count_in     = count_ff;
      nudges_in    = nudges_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      root_in      = root_ff;
      steps_in     = steps_ff;
      found_in     = found_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_TOLERANCE:  tol_in   = csr_wdata[TOL_BITS-1:0];
            CSR_ITER_LIMIT: lim_in   = csr_wdata[LIM_BITS-1:0];
            CSR_NUDGE_STEP: nudge_in = csr_wdata[NUDGE_BITS-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               a_in      = in_word(req_ch.coef_a);
               b_in      = in_word(req_ch.coef_b);
               c_in      = in_word(req_ch.coef_c);
               x_in      = in_word(req_ch.start_x);
               count_in  = '0;
               nudges_in = '0;
               state_in  = S_MAX;
            end
         end
         S_MAX: begin
            prod_in  = mul_p;
            neg_in   = mul_neg;
            state_in = S_SAX;
         end
         S_SAX: begin
            ax_in    = prod_sat;
            state_in = S_DER;
         end
         S_DER: begin
            d_in = d_calc;
            if (d_calc != '0) begin
               state_in = S_MAXX;
            end else if (nudges_ff <= lim_ext) begin
               x_in      = clamp_acc(ACC_BITS'(x_ff) + signed'(ACC_BITS'(nudge_ff)));
               nudges_in = nudges_ff + CNT_BITS'(1);
               state_in  = S_MAX;
            end else begin
               state_in = S_FIN;
            end
         end
         S_MAXX: begin
            prod_in  = mul_p;
            neg_in   = mul_neg;
            state_in = S_MBX;
         end
         S_MBX: begin
            axx_in   = prod_sat;
            prod_in  = mul_p;
            neg_in   = mul_neg;
            state_in = S_SUM;
         end
         S_SUM: begin
            bx_in    = prod_sat;
            state_in = S_FSUM;
         end
         S_FSUM: begin
            f_in     = clamp_acc(ACC_BITS'(part) + ACC_BITS'(c_ff));
            state_in = S_DVI;
         end
         S_DVI: begin
            quo_in   = {magnitude(f_ff), {FRAC_BITS{1'b0}}};
            rem_in   = '0;
            den_in   = magnitude(d_ff);
            qneg_in  = f_ff[WORD_BITS-1] ^ d_ff[WORD_BITS-1];
            dcnt_in  = DIV_CNT_BITS'(NUM_BITS);
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in  = qbit ? mag_type'(trial - {1'b0, den_ff}) : trial[WORD_BITS-1:0];
            quo_in  = {quo_ff[NUM_BITS-2:0], qbit};
            dcnt_in = dcnt_ff - DIV_CNT_BITS'(1);
            if (dcnt_ff == DIV_CNT_BITS'(1)) begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            x_in     = clamp_acc(ACC_BITS'(x_ff) - ACC_BITS'(delta));
            count_in = count_nx;
            if ((magnitude(delta) <= mag_type'(tol_ff)) || (count_nx > lim_ext) ||
                (nudges_ff > lim_ext)) begin
               state_in = S_FIN;
            end else begin
               state_in = S_MAX;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               root_in      = out_word(x_ff);
               steps_in     = ok ? count_ff[LIM_BITS-1:0] : '0;
               found_in     = ok;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         tol_ff       <= TOL_RESET;
         lim_ff       <= LIM_RESET;
         nudge_ff     <= NUDGE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         tol_ff       <= tol_in;
         lim_ff       <= lim_in;
         nudge_ff     <= nudge_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      b_ff      <= b_in;
      c_ff      <= c_in;
      x_ff      <= x_in;
      ax_ff     <= ax_in;
      axx_ff    <= axx_in;
      bx_ff     <= bx_in;
      d_ff      <= d_in;
      f_ff      <= f_in;
      prod_ff   <= prod_in;
      neg_ff    <= neg_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      quo_ff    <= quo_in;
      qneg_ff   <= qneg_in;
      dcnt_ff   <= dcnt_in;
      count_ff  <= count_in;
      nudges_ff <= nudges_in;
      root_ff   <= root_in;
      steps_ff  <= steps_in;
      found_ff  <= found_in;
   end

`ifndef SYNTHESIS
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < den_ff) && (dcnt_ff != '0))
      else $error("divider remainder or bit count out of range");

   a_upd_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD) |-> ($past(state_ff) == S_DIV))
      else $error("update entered without a finished division");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |->
         (count_ff <= lim_ext + CNT_BITS'(1)) && (nudges_ff <= lim_ext + CNT_BITS'(1)))
      else $error("step or nudge count past the limit");

   a_found_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (found_ff == (steps_ff != '0)))
      else $error("found flag disagrees with step count");
`endif

endmodule
